// ----- hdl/uest_pkg.sv -----
// ----------------------------------------------------------------------------
// uest_pkg
// Shared types and codes of the terminal key-sequence tokenizer.
// ----------------------------------------------------------------------------
package uest_pkg;

    localparam int SEQ_W     = 56;
    localparam int CP_W      = 21;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_CSI   = 3'd1;
    localparam logic [2:0] KIND_SS3   = 3'd2;
    localparam logic [2:0] KIND_ESCCH = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    typedef struct packed {
        logic [2:0]      token_kind;
        logic [CP_W-1:0] code_point;
        logic [7:0]      final_byte;
        logic [SEQ_W-1:0] seq_bytes;
        logic [2:0]      seq_len;
        logic            truncated;
        logic            last;
    } t_tok;

    // Up to two tokens produced by one byte, in order a then b.
    typedef struct packed {
        logic va;
        logic vb;
        t_tok a;
        t_tok b;
    } t_res;

endpackage

// ----- hdl/uest_if.sv -----
// ----------------------------------------------------------------------------
// uest_if
// Valid/ready channels of the tokenizer: byte requests in, token requests out.
// ----------------------------------------------------------------------------
interface uest_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface uest_tok_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [20:0] code_point;
    logic [7:0]  final_byte;
    logic [55:0] seq_bytes;
    logic [2:0]  seq_len;
    logic        truncated;
    logic        last;

    modport source (output valid, output token_kind, output code_point, output final_byte,
                    output seq_bytes, output seq_len, output truncated, output last,
                    input ready);
    modport sink   (input valid, input token_kind, input code_point, input final_byte,
                    input seq_bytes, input seq_len, input truncated, input last,
                    output ready);
endinterface

// ----- hdl/utf8_escape_sequence_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// utf8_escape_sequence_tokenizer_top
// Groups raw terminal bytes into UTF-8 character and escape-sequence tokens.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake     Carries
// i_byte_if  in   valid/ready   in_byte: one raw terminal byte per request
// o_tok_if   out  valid/ready   one token per request, last marks the final
//                               token caused by a byte
//
// A byte is registered on acceptance and parsed once the queue has room. One
// byte per cycle is sustained while the queue has room; the output side gives
// one token per cycle through a four-entry queue while ready is high, and a
// byte that causes two tokens hands them out one after the other. Reset
// (synchronous, active low) empties the queue and returns the parser to idle.
// A stalled output backs up the queue and then holds off input through ready.
// ----------------------------------------------------------------------------
module utf8_escape_sequence_tokenizer_top #(
    parameter int SEQ_BYTES = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uest_byte_if.sink  i_byte_if,
    uest_tok_if.source o_tok_if
);
    import uest_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       consume;
    t_res       res;
    t_tok       tok;

    assign consume         = r_in_valid && room;
    assign i_byte_if.ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_if.ready) begin
            r_in_valid <= i_byte_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_if.ready && i_byte_if.valid) begin
            r_in_byte <= i_byte_if.in_byte;
        end
    end

    uest_parse #(
        .SEQ_BYTES (SEQ_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (consume),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    uest_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_tok_if.valid),
        .i_ready (o_tok_if.ready),
        .o_tok   (tok)
    );

    assign o_tok_if.token_kind = tok.token_kind;
    assign o_tok_if.code_point = tok.code_point;
    assign o_tok_if.final_byte = tok.final_byte;
    assign o_tok_if.seq_bytes  = tok.seq_bytes;
    assign o_tok_if.seq_len    = tok.seq_len;
    assign o_tok_if.truncated  = tok.truncated;
    assign o_tok_if.last       = tok.last;

endmodule

// ----- hdl/uest_parse.sv -----
// ----------------------------------------------------------------------------
// uest_parse
// Parser state and single-pass next-state logic; yields up to two tokens/byte.
// ----------------------------------------------------------------------------
module uest_parse #(
    parameter int SEQ_BYTES = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_byte,
    output uest_pkg::t_res o_res
);
    import uest_pkg::*;

    localparam int HELD_W = 8 * SEQ_BYTES;
    localparam int CNT_W  = $clog2(SEQ_BYTES + 1);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_UTF8 = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_CSI  = 3'd3;
    localparam logic [2:0] MODE_SS3  = 3'd4;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    logic [2:0]        r_mode, n_mode;
    logic [HELD_W-1:0] r_held, n_held;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [1:0]        r_cont, n_cont;
    logic [CP_W-1:0]   r_acc,  n_acc;
    logic              r_ovf,  n_ovf;

    logic [HELD_W-1:0] h_held;
    logic [CNT_W-1:0]  h_cnt;
    logic              h_ovf;

    logic              s_emit;
    logic [2:0]        s_mode;
    logic [CP_W-1:0]   s_acc;
    logic [1:0]        s_cont;
    logic [HELD_W-1:0] s_held;

    logic              va, vb, restart, done;
    t_tok              ta, tb;
    logic [CP_W-1:0]   cp_next;
    logic              is_param, is_final, is_print;

    function automatic t_tok make_tok(input logic [2:0] kind, input logic [CP_W-1:0] cp,
                                      input logic [7:0] fb, input logic [HELD_W-1:0] held,
                                      input logic [CNT_W-1:0] cnt, input logic ovf);
        logic [63:0] wide;
        logic [3:0]  cnt4;
        t_tok        t;
        wide         = 64'(held);
        cnt4         = 4'(cnt);
        t.token_kind = kind;
        t.code_point = cp;
        t.final_byte = fb;
        t.seq_bytes  = wide[SEQ_W-1:0];
        t.seq_len    = cnt4[2:0];
        t.truncated  = ovf;
        t.last       = 1'b1;
        return t;
    endfunction

    // Append the byte to the held bytes, or flag the overflow.
    always_comb begin
        h_held = r_held;
        h_cnt  = r_cnt;
        h_ovf  = r_ovf;
        if (r_cnt < CNT_W'(SEQ_BYTES)) begin
            for (int i = 0; i < SEQ_BYTES; i++) begin
                if (r_cnt == CNT_W'(i)) begin
                    h_held[8*i +: 8] = i_byte;
                end
            end
            h_cnt = r_cnt + 1'b1;
        end else begin
            h_ovf = 1'b1;
        end
    end

    // Start of a fresh token from this byte.
    always_comb begin
        s_emit = 1'b0;
        s_mode = MODE_IDLE;
        s_acc  = '0;
        s_cont = 2'd0;
        s_held = HELD_W'(i_byte);
        if (i_byte == CH_ESC) begin
            s_mode = MODE_ESC;
        end else if (i_byte[7] == 1'b0) begin
            s_emit = 1'b1;
        end else if (i_byte[7:5] == 3'b110) begin
            s_acc  = CP_W'(i_byte[4:0]);
            s_cont = 2'd1;
            s_mode = MODE_UTF8;
        end else if (i_byte[7:4] == 4'b1110) begin
            s_acc  = CP_W'(i_byte[3:0]);
            s_cont = 2'd2;
            s_mode = MODE_UTF8;
        end else if (i_byte[7:3] == 5'b11110) begin
            s_acc  = CP_W'(i_byte[2:0]);
            s_cont = 2'd3;
            s_mode = MODE_UTF8;
        end else begin
            // stray continuation or invalid lead: plain one-byte character
            s_emit = 1'b1;
        end
    end

    assign cp_next  = {r_acc[CP_W-7:0], i_byte[5:0]};
    assign is_param = (i_byte >= 8'h30 && i_byte <= 8'h39) || i_byte == CH_SEMI;
    assign is_final = i_byte >= 8'd64 && i_byte <= 8'd126;
    assign is_print = i_byte >= 8'd32 && i_byte <= 8'd127;

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_cont  = r_cont;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        va      = 1'b0;
        restart = 1'b0;
        done    = 1'b0;
        ta      = make_tok(KIND_BAD, '0, 8'd0, r_held, r_cnt, r_ovf);
        unique case (r_mode)
            MODE_UTF8: begin
                if (i_byte[7:6] == 2'b10 && r_cont != 2'd0) begin
                    n_held = h_held;
                    n_cnt  = h_cnt;
                    n_ovf  = h_ovf;
                    n_acc  = cp_next;
                    n_cont = r_cont - 2'd1;
                    if (r_cont == 2'd1) begin
                        va   = 1'b1;
                        done = 1'b1;
                        ta   = make_tok(KIND_CHAR, cp_next, 8'd0, h_held, h_cnt, h_ovf);
                    end
                end else begin
                    va      = 1'b1;
                    restart = 1'b1;
                end
            end
            MODE_ESC: begin
                if (i_byte == CH_LBRK || i_byte == CH_O) begin
                    n_held = h_held;
                    n_cnt  = h_cnt;
                    n_ovf  = h_ovf;
                    n_mode = (i_byte == CH_LBRK) ? MODE_CSI : MODE_SS3;
                end else if (is_print) begin
                    va   = 1'b1;
                    done = 1'b1;
                    ta   = make_tok(KIND_ESCCH, '0, i_byte, h_held, h_cnt, h_ovf);
                end else begin
                    va      = 1'b1;
                    restart = 1'b1;
                end
            end
            MODE_CSI, MODE_SS3: begin
                if (is_param) begin
                    n_held = h_held;
                    n_cnt  = h_cnt;
                    n_ovf  = h_ovf;
                end else if (is_final) begin
                    va   = 1'b1;
                    done = 1'b1;
                    ta   = make_tok((r_mode == MODE_CSI) ? KIND_CSI : KIND_SS3, '0, i_byte,
                                    h_held, h_cnt, h_ovf);
                end else begin
                    va      = 1'b1;
                    restart = 1'b1;
                end
            end
            default: begin
                restart = 1'b1;
            end
        endcase

        if (done) begin
            n_mode = MODE_IDLE;
            n_held = '0;
            n_cnt  = '0;
            n_cont = 2'd0;
            n_acc  = '0;
            n_ovf  = 1'b0;
        end

        vb = restart && s_emit;
        tb = make_tok(KIND_CHAR, CP_W'(i_byte), 8'd0, s_held, CNT_W'(1), 1'b0);
        if (restart) begin
            n_mode = s_mode;
            n_held = s_emit ? '0 : s_held;
            n_cnt  = s_emit ? '0 : CNT_W'(1);
            n_cont = s_cont;
            n_acc  = s_acc;
            n_ovf  = 1'b0;
        end
        ta.last = !vb;
    end

    assign o_res.va = i_valid && va;
    assign o_res.vb = i_valid && vb;
    assign o_res.a  = ta;
    assign o_res.b  = tb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_held <= '0;
            r_cnt  <= '0;
            r_cont <= 2'd0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_valid) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_cnt  <= n_cnt;
            r_cont <= n_cont;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    a_pending_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_IDLE |-> r_cnt != '0)
        else $error("pending token with no held bytes");

    a_cont_only_utf8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cont != 2'd0 |-> r_mode == MODE_UTF8)
        else $error("continuation count outside a UTF-8 character");

    a_pair_starts_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.va && o_res.vb |-> o_res.a.token_kind == KIND_BAD)
        else $error("two tokens from one byte without a malformed first");

endmodule

// ----- hdl/uest_outq.sv -----
// ----------------------------------------------------------------------------
// uest_outq
// Small token queue: takes up to two tokens a cycle, hands out one a cycle while ready is high.
// ----------------------------------------------------------------------------
module uest_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  uest_pkg::t_res i_res,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output uest_pkg::t_tok o_tok
);
    import uest_pkg::*;

    t_tok               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic [Q_PTR_W-1:0] wr_b;
    logic               pop;

    assign o_valid = r_cnt != '0;
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a malformed token plus a re-parsed character
    assign o_room  = r_cnt <= Q_CNT_W'(Q_DEPTH - 2);
    assign wr_b    = r_wr + Q_PTR_W'(i_res.va);

    always_comb begin
        n_wr  = r_wr + Q_PTR_W'(i_res.va) + Q_PTR_W'(i_res.vb);
        n_rd  = r_rd + Q_PTR_W'(pop);
        n_cnt = r_cnt + Q_CNT_W'(i_res.va) + Q_CNT_W'(i_res.vb) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_res.va) begin
            r_mem[r_wr] <= i_res.a;
        end
        if (i_res.vb) begin
            r_mem[wr_b] <= i_res.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.va || i_res.vb) |-> r_cnt <= Q_CNT_W'(Q_DEPTH - 2))
        else $error("token pushed without room");

endmodule
